FILE: rtl/core/psds_pkg.sv
// ----------------------------------------------------------------------------
// psds_pkg
// Shared types and constants of the per-source delivery statistics block.
// ----------------------------------------------------------------------------
package psds_pkg;

    // default sizes
    localparam int DEF_MAX_SOURCES = 32;
    localparam int DEF_HIST_SLOTS  = 10;

    // register reset value
    localparam logic [15:0] EXP_INTERVAL_RESET = 16'd500;

    // payload widths
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 160;

    // result status codes
    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_DUPLICATE  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_CMP,
        S_ALLOC,
        S_SEQ,
        S_DEV,
        S_ACC,
        S_HRD,
        S_HCMP,
        S_HWR,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    set_st;
        status_t st_code;
        logic    idx_clr;
        logic    idx_inc;
        logic    ent_rd;
        logic    take_match;
        logic    alloc;
        logic    seq_upd;
        logic    dev_upd;
        logic    acc_upd;
        logic    h_rd;
        logic    h_cmp;
        logic    h_wr;
        logic    out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic incomplete;
        logic idx_end;
        logic full;
        logic match;
        logic dup;
        logic h_end;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/core/psds_ctrl.sv
// ----------------------------------------------------------------------------
// psds_ctrl
// Sequencer: source search, allocation, accumulation and histogram scan.
// ----------------------------------------------------------------------------
module psds_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  psds_pkg::sts_t sts,
    output psds_pkg::cmd_t cmd
);
    import psds_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.st_code = ST_ACCEPTED;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.idx_clr = 1'b1;
                if (sts.incomplete)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_INCOMPLETE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.idx_end)
                begin
                    if (sts.full)
                    begin
                        cmd.set_st  = 1'b1;
                        cmd.st_code = ST_TABLE_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.match)
                begin
                    cmd.take_match = 1'b1;
                    state_next     = S_SEQ;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_SEQ;
            end
            S_SEQ:
            begin
                if (sts.dup)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_DUPLICATE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.seq_upd = 1'b1;
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_ACCEPTED;
                    state_next  = S_DEV;
                end
            end
            S_DEV:
            begin
                cmd.dev_upd = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_upd = 1'b1;
                state_next  = S_HRD;
            end
            S_HRD:
            begin
                if (sts.h_end)
                begin
                    state_next = S_HWR;
                end
                else
                begin
                    cmd.h_rd   = 1'b1;
                    state_next = S_HCMP;
                end
            end
            S_HCMP:
            begin
                cmd.h_cmp  = 1'b1;
                state_next = S_HRD;
            end
            S_HWR:
            begin
                cmd.h_wr   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/psds_dp.sv
// ----------------------------------------------------------------------------
// psds_dp
// Datapath: source table, histogram memories, sums and the result register.
// ----------------------------------------------------------------------------
module psds_dp #(
    parameter int MAX_SOURCES = psds_pkg::DEF_MAX_SOURCES,
    parameter int HIST_SLOTS  = psds_pkg::DEF_HIST_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [psds_pkg::S_DATA_W-1:0] in_data,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata,
    input  psds_pkg::cmd_t                cmd,
    output psds_pkg::sts_t                sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [psds_pkg::M_DATA_W-1:0] out_data
);
    import psds_pkg::*;

    localparam int IW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int SW  = $clog2(MAX_SOURCES + 1);
    localparam int HW  = $clog2(HIST_SLOTS + 1);
    localparam int HD  = MAX_SOURCES * HIST_SLOTS;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // latched report
    logic [15:0] src_reg, seq_reg, par_reg;
    logic [7:0]  hop_reg;
    logic [31:0] now_reg;

    // configuration and global counters
    logic [15:0]   exp_reg;
    logic [SW-1:0] seen_reg;
    logic [31:0]   total_reg;

    // search and working record
    logic [SW-1:0] idx_reg;
    logic [IW-1:0] slot_reg;
    logic [15:0]   w_seq_reg, w_pkts_reg;
    logic [31:0]   w_lms_reg, w_gap_reg, w_dev_reg;
    logic [HW-1:0] w_pf_reg, w_hf_reg;
    logic          first_reg;
    logic [31:0]   gap_reg, dev_reg;

    // result flags
    status_t       st_reg;
    logic          fresh_reg, have_reg;
    logic [15:0]   phits_reg, hhits_reg;

    // histogram scan
    logic [HAW-1:0] base_reg;
    logic [HW-1:0]  hidx_reg;
    logic           pfound_reg, hfound_reg;
    logic [HW-1:0]  pidx_reg, hsel_reg;
    logic [15:0]    pcnt_reg, hcnt_reg;

    // output register
    logic                valid_reg;
    logic [M_DATA_W-1:0] out_reg;

    // source table memory
    logic [15:0] m_addr [MAX_SOURCES];
    logic [15:0] m_seq  [MAX_SOURCES];
    logic [15:0] m_pkts [MAX_SOURCES];
    logic [31:0] m_lms  [MAX_SOURCES];
    logic [31:0] m_gap  [MAX_SOURCES];
    logic [31:0] m_dev  [MAX_SOURCES];
    logic [HW-1:0] m_pf [MAX_SOURCES];
    logic [HW-1:0] m_hf [MAX_SOURCES];
    logic [15:0] r_addr, r_seq, r_pkts;
    logic [31:0] r_lms, r_gap, r_dev;
    logic [HW-1:0] r_pf, r_hf;

    // histogram memories
    logic [15:0] pm_id  [HD];
    logic [15:0] pm_cnt [HD];
    logic [7:0]  hm_val [HD];
    logic [15:0] hm_cnt [HD];
    logic [15:0] r_pid, r_pcnt, r_hcnt;
    logic [7:0]  r_hval;

    logic [HAW-1:0] h_addr;
    logic [15:0]    pcnt_new, hcnt_new;
    logic           p_room, h_room;
    logic [HW-1:0]  pf_new, hf_new;

    assign h_addr = base_reg + HAW'(hidx_reg);
    assign p_room = (w_pf_reg < HW'(HIST_SLOTS));
    assign h_room = (w_hf_reg < HW'(HIST_SLOTS));
    assign pcnt_new = sat_inc16(pcnt_reg);
    assign hcnt_new = sat_inc16(hcnt_reg);
    assign pf_new = (!pfound_reg && p_room) ? w_pf_reg + HW'(1) : w_pf_reg;
    assign hf_new = (!hfound_reg && h_room) ? w_hf_reg + HW'(1) : w_hf_reg;

    // status to the controller
    assign sts.incomplete = (seq_reg == 16'd0) || (par_reg == 16'd0) || (hop_reg == 8'd0);
    assign sts.idx_end    = (idx_reg == seen_reg);
    assign sts.full       = (seen_reg == SW'(MAX_SOURCES));
    assign sts.match      = (r_addr == src_reg);
    assign sts.dup        = (seq_reg <= w_seq_reg);
    assign sts.h_end      = (hidx_reg == HW'(HIST_SLOTS));
    assign sts.out_free   = !valid_reg || out_ready;

    // source table read and write
    always_ff @(posedge clk)
    begin
        if (cmd.ent_rd)
        begin
            r_addr <= m_addr[idx_reg[IW-1:0]];
            r_seq  <= m_seq[idx_reg[IW-1:0]];
            r_pkts <= m_pkts[idx_reg[IW-1:0]];
            r_lms  <= m_lms[idx_reg[IW-1:0]];
            r_gap  <= m_gap[idx_reg[IW-1:0]];
            r_dev  <= m_dev[idx_reg[IW-1:0]];
            r_pf   <= m_pf[idx_reg[IW-1:0]];
            r_hf   <= m_hf[idx_reg[IW-1:0]];
        end
        if (cmd.h_wr)
        begin
            m_addr[slot_reg] <= src_reg;
            m_seq[slot_reg]  <= w_seq_reg;
            m_pkts[slot_reg] <= w_pkts_reg;
            m_lms[slot_reg]  <= w_lms_reg;
            m_gap[slot_reg]  <= w_gap_reg;
            m_dev[slot_reg]  <= w_dev_reg;
            m_pf[slot_reg]   <= pf_new;
            m_hf[slot_reg]   <= hf_new;
        end
    end

    // parent histogram memory
    always_ff @(posedge clk)
    begin
        if (cmd.h_rd)
        begin
            r_pid  <= pm_id[h_addr];
            r_pcnt <= pm_cnt[h_addr];
        end
        if (cmd.h_wr)
        begin
            if (pfound_reg)
            begin
                pm_cnt[base_reg + HAW'(pidx_reg)] <= pcnt_new;
            end
            else if (p_room)
            begin
                pm_id[base_reg + HAW'(w_pf_reg)]  <= par_reg;
                pm_cnt[base_reg + HAW'(w_pf_reg)] <= 16'd1;
            end
        end
    end

    // hop histogram memory
    always_ff @(posedge clk)
    begin
        if (cmd.h_rd)
        begin
            r_hval <= hm_val[h_addr];
            r_hcnt <= hm_cnt[h_addr];
        end
        if (cmd.h_wr)
        begin
            if (hfound_reg)
            begin
                hm_cnt[base_reg + HAW'(hsel_reg)] <= hcnt_new;
            end
            else if (h_room)
            begin
                hm_val[base_reg + HAW'(w_hf_reg)] <= hop_reg;
                hm_cnt[base_reg + HAW'(w_hf_reg)] <= 16'd1;
            end
        end
    end

    // report capture and working record
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            src_reg <= in_data[15:0];
            seq_reg <= in_data[31:16];
            par_reg <= in_data[47:32];
            hop_reg <= in_data[55:48];
            now_reg <= in_data[103:72];
        end
        if (cmd.take_match)
        begin
            slot_reg   <= idx_reg[IW-1:0];
            w_seq_reg  <= r_seq;
            w_pkts_reg <= r_pkts;
            w_lms_reg  <= r_lms;
            w_gap_reg  <= r_gap;
            w_dev_reg  <= r_dev;
            w_pf_reg   <= r_pf;
            w_hf_reg   <= r_hf;
        end
        if (cmd.alloc)
        begin
            slot_reg   <= seen_reg[IW-1:0];
            w_seq_reg  <= 16'd0;
            w_pkts_reg <= 16'd0;
            w_gap_reg  <= 32'd0;
            w_dev_reg  <= 32'd0;
            w_pf_reg   <= '0;
            w_hf_reg   <= '0;
        end
        // sequence check passed: gap and slot base
        if (cmd.seq_upd)
        begin
            w_seq_reg  <= seq_reg;
            first_reg  <= (w_pkts_reg == 16'd0);
            gap_reg    <= now_reg - w_lms_reg;
            w_lms_reg  <= now_reg;
            w_pkts_reg <= sat_inc16(w_pkts_reg);
            base_reg   <= HAW'(32'(slot_reg) * HIST_SLOTS);
        end
        if (cmd.dev_upd)
        begin
            dev_reg <= (gap_reg >= {16'd0, exp_reg}) ? gap_reg - {16'd0, exp_reg}
                                                     : {16'd0, exp_reg} - gap_reg;
        end
        if (cmd.acc_upd && !first_reg)
        begin
            w_gap_reg <= sat_add32(w_gap_reg, gap_reg);
            w_dev_reg <= sat_add32(w_dev_reg, dev_reg);
        end
        // histogram scan compare
        if (cmd.acc_upd)
        begin
            pfound_reg <= 1'b0;
            hfound_reg <= 1'b0;
        end
        if (cmd.h_cmp)
        begin
            if (!pfound_reg && (hidx_reg < w_pf_reg) && (r_pid == par_reg))
            begin
                pfound_reg <= 1'b1;
                pidx_reg   <= hidx_reg;
                pcnt_reg   <= r_pcnt;
            end
            if (!hfound_reg && (hidx_reg < w_hf_reg) && (r_hval == hop_reg))
            begin
                hfound_reg <= 1'b1;
                hsel_reg   <= hidx_reg;
                hcnt_reg   <= r_hcnt;
            end
        end
        if (cmd.load_in)
        begin
            phits_reg <= 16'd0;
            hhits_reg <= 16'd0;
        end
        if (cmd.h_wr)
        begin
            phits_reg <= pfound_reg ? pcnt_new : (p_room ? 16'd1 : 16'd0);
            hhits_reg <= hfound_reg ? hcnt_new : (h_room ? 16'd1 : 16'd0);
        end
        if (cmd.out_load)
        begin
            out_reg[1:0]     <= st_reg;
            out_reg[2]       <= fresh_reg;
            out_reg[7:3]     <= have_reg ? 5'(slot_reg) : 5'd0;
            out_reg[23:8]    <= have_reg ? w_pkts_reg : 16'd0;
            out_reg[55:24]   <= have_reg ? w_gap_reg : 32'd0;
            out_reg[87:56]   <= have_reg ? w_dev_reg : 32'd0;
            out_reg[103:88]  <= phits_reg;
            out_reg[119:104] <= hhits_reg;
            out_reg[151:120] <= total_reg;
            out_reg[157:152] <= 6'(seen_reg);
            out_reg[159:158] <= 2'd0;
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg   <= EXP_INTERVAL_RESET;
            seen_reg  <= '0;
            total_reg <= 32'd0;
            idx_reg   <= '0;
            hidx_reg  <= '0;
            st_reg    <= ST_INCOMPLETE;
            fresh_reg <= 1'b0;
            have_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                exp_reg <= cfg_wdata;
            end
            if (cmd.load_in)
            begin
                fresh_reg <= 1'b0;
                have_reg  <= 1'b0;
            end
            if (cmd.set_st)
            begin
                st_reg <= cmd.st_code;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + SW'(1);
            end
            if (cmd.take_match)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.alloc)
            begin
                have_reg  <= 1'b1;
                fresh_reg <= 1'b1;
                seen_reg  <= seen_reg + SW'(1);
            end
            if (cmd.seq_upd)
            begin
                total_reg <= sat_add32(total_reg, 32'd1);
            end
            if (cmd.acc_upd)
            begin
                hidx_reg <= '0;
            end
            else if (cmd.h_cmp)
            begin
                hidx_reg <= hidx_reg + HW'(1);
            end
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/per_source_delivery_statistics.sv
// ----------------------------------------------------------------------------
// per_source_delivery_statistics
// Per-source delivery statistics over a stream of received reports.
// ----------------------------------------------------------------------------
// One report in, one result out, one report at a time: no new report is
// taken until the result of the last one is loaded. An incomplete report
// goes straight to the result. A known source is found by walking the
// table up to and including the match; a new source walks all N sources
// seen so far and is then allocated, and a report dropped because the
// table is full walks all MAX_SOURCES entries. A duplicate ends after the
// walk; an accepted report updates the entry and scans all HIST_SLOTS
// histogram slots. The table and the histograms sit in single-port
// memories that are walked one entry at a time, with a read state and a
// compare state per entry. With the defaults the worst case is a new
// source when 31 are already known. The result waits in an output register,
// and while it is not taken the next result cannot be loaded and the block stalls.
module per_source_delivery_statistics #(
    parameter int MAX_SOURCES = psds_pkg::DEF_MAX_SOURCES,
    parameter int HIST_SLOTS  = psds_pkg::DEF_HIST_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // source_addr, seq_number, parent_addr, hop_distance, link_strength, arrival_ms
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psds_pkg::S_DATA_W-1:0] s_tdata,
    // status, new_source, entry_slot, source_packets, gap_sum, deviation_sum,
    // parent_hits, hop_hits, total_packets, source_total, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psds_pkg::M_DATA_W-1:0] m_tdata,
    // expected_interval_ms
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [15:0]                   cfg_data
);
    import psds_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    psds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    psds_dp #(
        .MAX_SOURCES (MAX_SOURCES),
        .HIST_SLOTS  (HIST_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_wdata (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

FILE: rtl/core/psds_checker.sv
// ----------------------------------------------------------------------------
// psds_checker
// Port-level checks of the per-source delivery statistics block.
// ----------------------------------------------------------------------------
module psds_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [psds_pkg::M_DATA_W-1:0] m_tdata
);
    import psds_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one report at a time
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // no histogram hits unless the report was accepted
    a_hits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_ACCEPTED) |-> (m_tdata[119:88] == 32'd0))
        else $error("hits reported for a dropped report");

    // no entry fields without an entry
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_INCOMPLETE || m_tdata[1:0] == ST_TABLE_FULL)
        |-> (m_tdata[87:2] == 86'd0))
        else $error("entry fields set without an entry");

endmodule

bind per_source_delivery_statistics psds_checker u_psds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
